@@ hw/rtl/sha256_message_hasher_macros.svh @@
// Assertion macros used by the hasher control (sha256_ctrl).
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

`ifndef SYNTHESIS
`define SHA_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("sha256 check failed: same-cycle implication");
`define SHA_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("sha256 check failed: next-cycle implication");
`else
`define SHA_ASSERT_NOW(label, clock, reset, ante, cons)
`define SHA_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

@@ hw/rtl/sha256_pkg.sv @@
package sha256_pkg;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] LEN_LAST   = 3'd7;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_UPDATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       load_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       update;
    logic       reinit;
  } ctrl_t;

  localparam logic [31:0] K_ROUND [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ hw/rtl/sha256_in_if.sv @@
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

@@ hw/rtl/sha256_out_if.sv @@
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word_0;
  logic [31:0] digest_word_1;
  logic [31:0] digest_word_2;
  logic [31:0] digest_word_3;
  logic [31:0] digest_word_4;
  logic [31:0] digest_word_5;
  logic [31:0] digest_word_6;
  logic [31:0] digest_word_7;

  modport source (
    output valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
           digest_word_4, digest_word_5, digest_word_6, digest_word_7,
    input ready
  );
  modport sink (
    input valid, digest_word_0, digest_word_1, digest_word_2, digest_word_3,
          digest_word_4, digest_word_5, digest_word_6, digest_word_7,
    output ready
  );
endinterface

@@ hw/rtl/sha256_message_hasher.sv @@
// SHA-256 over a byte stream. Each msg transfer carries at most one byte
// (has_byte) and may close the message (end_of_message); the closing transfer
// yields one digest transfer of eight big-endian words, after which the hash
// restarts for the next message. A byte that does not complete a 64-byte block
// is taken without stalling msg. Completing a block runs 64 rounds on
// the single shared round unit, then the hash update (the working registers
// load on the accepting edge), with msg held not ready. Closing a message
// pushes the padding and length one byte per cycle (9 to 72 bytes) with one
// or two block compressions, then waits in S_DONE until the output register
// is free and hands the digest to it.
// The next message may start while the digest still waits to be taken.
module sha256_message_hasher
  import sha256_pkg::*;
(
  input logic         clk,
  input logic         rst,
  sha256_in_if.sink   msg,
  sha256_out_if.source digest
);

  ctrl_t       ctl;
  logic        out_busy;
  logic        out_load;
  logic [31:0] w_top;
  logic [31:0] hash [8];
  logic        out_valid;
  logic [31:0] out_words [8];

  assign out_busy = out_valid && !digest.ready;

  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg.valid),
    .in_byte  (msg.data_byte),
    .in_has   (msg.has_byte),
    .in_eom   (msg.end_of_message),
    .out_busy (out_busy),
    .in_ready (msg.ready),
    .out_load (out_load),
    .ctl      (ctl)
  );

  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_top (w_top)
  );

  sha256_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .w      (w_top),
    .digest (hash)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_words <= hash;
  end

  assign digest.valid         = out_valid;
  assign digest.digest_word_0 = out_words[0];
  assign digest.digest_word_1 = out_words[1];
  assign digest.digest_word_2 = out_words[2];
  assign digest.digest_word_3 = out_words[3];
  assign digest.digest_word_4 = out_words[4];
  assign digest.digest_word_5 = out_words[5];
  assign digest.digest_word_6 = out_words[6];
  assign digest.digest_word_7 = out_words[7];

endmodule

@@ hw/rtl/sha256_sched.sv @@
module sha256_sched
  import sha256_pkg::*;
(
  input  logic        clk,
  input  ctrl_t       ctl,
  output logic [31:0] w_top
);

  // Block line: bytes enter at the bottom; word 0 (oldest) sits at the top.
  logic [511:0] line;
  logic [31:0]  w_new;

  function automatic logic [31:0] word_at(input logic [511:0] v, input int unsigned j);
    return v[511 - 32 * j -: 32];
  endfunction

  assign w_top = word_at(line, 0);
  assign w_new = word_at(line, 0) + small_sigma0(word_at(line, 1))
               + word_at(line, 9) + small_sigma1(word_at(line, 14));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      line <= {line[503:0], ctl.push_byte};
    end else if (ctl.round_en) begin
      line <= {line[479:0], w_new};
    end
  end

endmodule

@@ hw/rtl/sha256_core.sv @@
module sha256_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctl,
  input  logic [31:0] w,
  output logic [31:0] digest [8]
);

  logic [31:0] hash [8];
  logic [31:0] work [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = work[7] + big_sigma1(work[4])
            + ((work[4] & work[5]) ^ (~work[4] & work[6]))
            + K_ROUND[ctl.round_idx] + w;
  assign t2 = big_sigma0(work[0])
            + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= H_INIT;
    end else if (ctl.reinit) begin
      hash <= H_INIT;
    end else if (ctl.update) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_work) begin
      work <= hash;
    end else if (ctl.round_en) begin
      work[0] <= t1 + t2;
      work[1] <= work[0];
      work[2] <= work[1];
      work[3] <= work[2];
      work[4] <= work[3] + t1;
      work[5] <= work[4];
      work[6] <= work[5];
      work[7] <= work[6];
    end
  end

  assign digest = hash;

endmodule

@@ hw/rtl/sha256_ctrl.sv @@
`include "sha256_message_hasher_macros.svh"

module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_has,
  input  logic       in_eom,
  input  logic       out_busy,
  output logic       in_ready,
  output logic       out_load,
  output ctrl_t      ctl
);

  state_t      state;
  state_t      state_next;
  state_t      ret_state;
  logic [5:0]  fill;
  logic [60:0] msg_count;
  logic        pad_mark;
  logic        len_active;
  logic [2:0]  len_idx;
  logic [5:0]  round;

  logic        accept;
  logic        len_phase;
  logic [63:0] len_shift;

  assign accept    = in_valid && in_ready;
  assign len_phase = !pad_mark && (len_active || fill == FILL_LEN);
  assign len_shift = {msg_count, 3'b000} << {len_idx, 3'b000};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_has && fill == FILL_LAST) state_next = S_COMP;
          else if (in_eom)                 state_next = S_PAD;
        end
      end
      S_PAD: begin
        if (fill == FILL_LAST) state_next = S_COMP;
      end
      S_COMP: begin
        if (round == ROUND_LAST) state_next = S_UPDATE;
      end
      S_UPDATE: state_next = ret_state;
      S_DONE: begin
        if (!out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    ctl           = '0;
    ctl.round_idx = round;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        ctl.push      = accept && in_has;
        ctl.push_byte = in_byte;
        ctl.load_work = accept && in_has && fill == FILL_LAST;
      end
      S_PAD: begin
        ctl.push      = 1'b1;
        ctl.push_byte = pad_mark ? PAD_MARK : (len_phase ? len_shift[63:56] : 8'h00);
        ctl.load_work = fill == FILL_LAST;
      end
      S_COMP:   ctl.round_en = 1'b1;
      S_UPDATE: ctl.update = 1'b1;
      S_DONE: begin
        out_load   = !out_busy;
        ctl.reinit = !out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      fill       <= '0;
      msg_count  <= '0;
      pad_mark   <= 1'b0;
      len_active <= 1'b0;
      len_idx    <= '0;
      round      <= '0;
    end else begin
      state <= state_next;
      if (ctl.push) fill <= fill + 6'd1;
      if (ctl.round_en) round <= round + 6'd1;
      if (accept) begin
        ret_state <= in_eom ? S_PAD : S_IDLE;
        if (in_has) msg_count <= msg_count + 61'd1;
        if (in_eom) begin
          pad_mark   <= 1'b1;
          len_active <= 1'b0;
          len_idx    <= '0;
        end
      end
      if (state == S_PAD) begin
        if (pad_mark) begin
          pad_mark <= 1'b0;
        end else if (len_phase) begin
          len_active <= 1'b1;
          len_idx    <= len_idx + 3'd1;
        end
        if (fill == FILL_LAST) begin
          ret_state <= (len_phase && len_idx == LEN_LAST) ? S_DONE : S_PAD;
        end
      end
      if (out_load) msg_count <= '0;
    end
  end

  `SHA_ASSERT_NEXT(a_last_round, clk, rst, state == S_COMP && round == ROUND_LAST, state == S_UPDATE)
  `SHA_ASSERT_NOW(a_push_excl, clk, rst, ctl.push, !ctl.round_en && !ctl.update && !ctl.reinit)
  `SHA_ASSERT_NEXT(a_block_full, clk, rst, ctl.push && fill == FILL_LAST, state == S_COMP && round == '0)

endmodule

@@ sim/tb_sha256_message_hasher.sv @@
module tb_sha256_message_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 800;
  localparam int TAIL_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    bit         wait_drain;
  } msg_item_t;

  typedef logic [255:0] digest_t;

  logic clk;
  logic rst;

  sha256_in_if  msg_bus ();
  sha256_out_if dig_bus ();

  sha256_message_hasher u_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_bus),
    .digest (dig_bus)
  );

  msg_item_t   pending_q [$];
  digest_t     digest_q [$];
  msg_item_t   offered;

  logic [31:0] hv [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill_cnt;
  logic [60:0] msg_len;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_reqs;
  int          hold_served;
  int          hold_left;
  int          fail_count;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++)
      r[i] = hv[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[i] + w[i];
      t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6];
      r[6] = r[5];
      r[5] = r[4];
      r[4] = r[3] + t1;
      r[3] = r[2];
      r[2] = r[1];
      r[1] = r[0];
      r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      hv[i] = hv[i] + r[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    blk[fill_cnt] = b;
    fill_cnt = fill_cnt + 6'd1;
    if (fill_cnt == 6'd0)
      hash_block();
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++)
      hv[i] = HASH_IV[i];
    fill_cnt = '0;
    msg_len = '0;
  endfunction

  // Updates the running hash for one accepted transfer; queues the digest on close.
  function automatic void hash_transfer(input msg_item_t it);
    logic [63:0] bit_len;
    digest_t d;
    if (it.has_byte) begin
      absorb_byte(it.data_byte);
      msg_len = msg_len + 61'd1;
    end
    if (it.end_of_message) begin
      bit_len = {msg_len, 3'b000};
      absorb_byte(PAD_BYTE);
      while (fill_cnt != LEN_OFFSET)
        absorb_byte(8'h00);
      for (int i = 0; i < 8; i++)
        absorb_byte(bit_len[63 - 8*i -: 8]);
      for (int k = 0; k < 8; k++)
        d[255 - 32*k -: 32] = hv[k];
      digest_q.push_back(d);
      restart_hash();
    end
  endfunction

  function automatic void note_failure(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
  endfunction

  task automatic push_item(input logic [7:0] b, input logic has, input logic eom);
    msg_item_t it;
    it.data_byte = b;
    it.has_byte = has;
    it.end_of_message = eom;
    it.wait_drain = 1'b0;
    pending_q.push_back(it);
  endtask

  task automatic push_drain();
    msg_item_t it;
    it = '{8'h00, 1'b0, 1'b0, 1'b1};
    pending_q.push_back(it);
  endtask

  // Queues one message of len bytes with idle transfers mixed in at random; returns transfers used, idle ones apart.
  task automatic push_message(input int len, output int used);
    logic eom_on_byte;
    used = 0;
    eom_on_byte = (len != 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0)
        push_item(8'($urandom_range(255)), 1'b0, 1'b0);
      push_item(8'($urandom_range(255)), 1'b1, eom_on_byte && (i == len - 1));
      used++;
    end
    if (!eom_on_byte) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
      used++;
    end
  endtask

  task automatic push_random_phase(input int min_items, input int min_msgs);
    int items;
    int msgs;
    int len;
    int used;
    items = 0;
    msgs = 0;
    while (items < min_items || msgs < min_msgs) begin
      case ($urandom_range(15))
        0: len = $urandom_range(53, 58);
        1: len = $urandom_range(62, 66);
        2: len = $urandom_range(118, 122);
        default: len = $urandom_range(0, 10);
      endcase
      push_message(len, used);
      items += used;
      msgs++;
    end
  endtask

  task automatic wait_sent();
    while (pending_q.size() != 0 || msg_bus.valid)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender
  always @(posedge clk) begin
    if (rst) begin
      msg_bus.valid <= 1'b0;
      msg_bus.data_byte <= '0;
      msg_bus.has_byte <= 1'b0;
      msg_bus.end_of_message <= 1'b0;
      restart_hash();
    end else begin
      if (msg_bus.valid && msg_bus.ready)
        hash_transfer(offered);
      if (!msg_bus.valid || msg_bus.ready) begin
        if (pending_q.size() != 0 && pending_q[0].wait_drain && digest_q.size() == 0)
          void'(pending_q.pop_front());
        if (pending_q.size() != 0 && !pending_q[0].wait_drain &&
            $urandom_range(99) >= send_idle_pct) begin
          offered = pending_q.pop_front();
          msg_bus.valid <= 1'b1;
          msg_bus.data_byte <= offered.data_byte;
          msg_bus.has_byte <= offered.has_byte;
          msg_bus.end_of_message <= offered.end_of_message;
        end else begin
          msg_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      dig_bus.ready <= 1'b0;
      hold_served <= 0;
      hold_left <= 0;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      dig_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      dig_bus.ready <= 1'b0;
    end else begin
      dig_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Digest checker
  always @(posedge clk) begin
    digest_t got;
    digest_t want;
    if (!rst && dig_bus.valid && dig_bus.ready) begin
      got = {dig_bus.digest_word_0, dig_bus.digest_word_1, dig_bus.digest_word_2,
             dig_bus.digest_word_3, dig_bus.digest_word_4, dig_bus.digest_word_5,
             dig_bus.digest_word_6, dig_bus.digest_word_7};
      if (digest_q.size() == 0) begin
        note_failure("digest transfer with none pending, word 0", 32'h0, got[255 -: 32]);
      end else begin
        want = digest_q.pop_front();
        for (int k = 0; k < 8; k++)
          if (got[255 - 32*k -: 32] !== want[255 - 32*k -: 32])
            note_failure($sformatf("digest_word_%0d", k),
                         want[255 - 32*k -: 32], got[255 - 32*k -: 32]);
      end
    end
  end

  initial begin
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle transfers, empty message, single extreme bytes, short text
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'h55, 1'b1, 1'b0);
    push_item(8'haa, 1'b0, 1'b0);
    push_item(8'h81, 1'b1, 1'b0);
    push_item(8'h7e, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    wait_sent();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random_phase(110, 5);
    wait_sent();

    send_idle_pct = 48;
    recv_stall_pct = 0;
    push_random_phase(110, 5);
    push_drain();
    wait_sent();

    send_idle_pct = 0;
    recv_stall_pct = 48;
    hold_reqs = hold_reqs + 1;
    push_random_phase(110, 5);
    wait_sent();

    send_idle_pct = 15;
    recv_stall_pct = 15;
    push_random_phase(55, 3);
    push_drain();
    push_random_phase(55, 2);
    wait_sent();

    while (digest_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sha256_message_hasher.f @@
+incdir+hw/rtl
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_in_if.sv
hw/rtl/sha256_out_if.sv
hw/rtl/sha256_sched.sv
hw/rtl/sha256_core.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_message_hasher.sv
sim/tb_sha256_message_hasher.sv
